// ===== rtl/lfupr_pkg.sv =====
// Shared types and constants for the LFU page replacement block.
`default_nettype none
package lfupr_pkg;

    localparam int COUNT_W = 16;
    localparam int STAMP_W = 32;
    localparam int TOTAL_W = 32;
    localparam int SLOT_W  = 3;
    localparam int CFG_W   = 4;
    localparam int PAGE_W  = 16;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [TOTAL_W-1:0] t_total;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic start;
        logic dv;
    } t_scan_ctl;

endpackage
`default_nettype wire

// ===== rtl/lfupr_frame_mem.sv =====
// Frame table memory: page, use count and last-use stamp per frame.
`default_nettype none
module lfupr_frame_mem import lfupr_pkg::*; #(
    parameter int DEPTH     = 8,
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 3
) (
    input  wire logic                 i_clk,
    input  wire logic [IDX_W-1:0]     i_rd_addr,
    output logic      [PAGE_BITS-1:0] o_rd_page,
    output t_count                    o_rd_count,
    output t_stamp                    o_rd_stamp,
    input  wire logic                 i_wr_en,
    input  wire logic [IDX_W-1:0]     i_wr_addr,
    input  wire logic [PAGE_BITS-1:0] i_wr_page,
    input  wire t_count               i_wr_count,
    input  wire t_stamp               i_wr_stamp
);

    logic [PAGE_BITS-1:0] r_page_mem  [DEPTH];
    t_count               r_count_mem [DEPTH];
    t_stamp               r_stamp_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_page_mem[i_wr_addr]  <= i_wr_page;
            r_count_mem[i_wr_addr] <= i_wr_count;
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_page  <= r_page_mem[i_rd_addr];
        o_rd_count <= r_count_mem[i_rd_addr];
        o_rd_stamp <= r_stamp_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/lfupr_scan.sv =====
// Scan unit: one frame per cycle for hit match, first empty frame and LFU/LRU victim.
`default_nettype none
module lfupr_scan import lfupr_pkg::*; #(
    parameter int PAGE_BITS = 16,
    parameter int IDX_W     = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_scan_ctl            i_ctl,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic                 i_valid,
    input  wire logic [PAGE_BITS-1:0] i_key,
    input  wire logic [PAGE_BITS-1:0] i_rd_page,
    input  wire t_count               i_rd_count,
    input  wire t_stamp               i_rd_stamp,
    output logic                      o_hit_found,
    output logic      [IDX_W-1:0]     o_hit_idx,
    output t_count                    o_hit_count,
    output logic                      o_empty_found,
    output logic      [IDX_W-1:0]     o_empty_idx,
    output logic      [IDX_W-1:0]     o_victim_idx,
    output logic      [PAGE_BITS-1:0] o_victim_page
);

    logic   r_hit_found;
    logic   r_empty_found;
    t_count r_victim_count;
    t_stamp r_victim_stamp;
    logic   w_match;
    logic   w_better;

    assign w_match  = i_valid && (i_rd_page == i_key);
    assign w_better = (i_idx == '0) || (i_rd_count < r_victim_count) ||
                      ((i_rd_count == r_victim_count) && (i_rd_stamp < r_victim_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (i_ctl.dv) begin
            if (w_match) begin
                r_hit_found <= 1'b1;
            end
            if (!i_valid) begin
                r_empty_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dv) begin
            if (w_match && !r_hit_found) begin
                o_hit_idx   <= i_idx;
                o_hit_count <= i_rd_count;
            end
            if (!i_valid && !r_empty_found) begin
                o_empty_idx <= i_idx;
            end
            if (w_better) begin
                o_victim_idx   <= i_idx;
                o_victim_page  <= i_rd_page;
                r_victim_count <= i_rd_count;
                r_victim_stamp <= i_rd_stamp;
            end
        end
    end

    assign o_hit_found   = r_hit_found;
    assign o_empty_found = r_empty_found;

endmodule
`default_nettype wire

// ===== rtl/lfu_page_replacement.sv =====
// Top level of the LFU page replacement block with LRU tie-break.
// Each page word is checked against the active frames. The frame table sits in a memory
// with one read port, scanned one frame per cycle; match, first empty frame and victim
// (least use count, then oldest stamp, then lowest index) come out of the same pass.
// From acceptance the block scans the active frames, drains the memory read and then
// registers the result in its update step; the next word is taken only back in idle.
// No clearing pass is needed after reset: per-frame valid bits mark empty frames.
// The result register frees the scan from the output side, so a waiting result only holds
// the block in its update step.
`default_nettype none
module lfu_page_replacement import lfupr_pkg::*; #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [PAGE_W-1:0] i_page,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_hit,
    output logic      [SLOT_W-1:0] o_slot,
    output logic                   o_evicted_valid,
    output logic      [PAGE_W-1:0] o_evicted_page,
    output t_total                 o_hit_total,
    output t_total                 o_miss_total
);

    localparam int IDX_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LAST_RST = ((MAX_FRAMES < 8) ? MAX_FRAMES : 8) - 1;

    t_state                  r_state;
    t_state                  n_state;
    logic [IDX_W-1:0]        r_last;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        r_didx;
    logic                    r_dv;
    logic [PAGE_BITS-1:0]    r_key;
    logic [MAX_FRAMES-1:0]   r_valid;
    t_stamp                  r_stamp;
    t_total                  r_hits;
    t_total                  r_misses;

    logic                    w_accept;
    logic                    w_scan;
    logic                    w_commit;
    t_scan_ctl               w_ctl;

    logic [PAGE_BITS+PAGE_W-1:0] w_page_ext;
    logic [PAGE_BITS+PAGE_W-1:0] w_evict_ext;
    logic [IDX_W+SLOT_W-1:0]     w_slot_ext;

    logic [PAGE_BITS-1:0]    w_rd_page;
    t_count                  w_rd_count;
    t_stamp                  w_rd_stamp;

    logic                    w_hit_found;
    logic [IDX_W-1:0]        w_hit_idx;
    t_count                  w_hit_count;
    logic                    w_empty_found;
    logic [IDX_W-1:0]        w_empty_idx;
    logic [IDX_W-1:0]        w_victim_idx;
    logic [PAGE_BITS-1:0]    w_victim_page;

    logic [IDX_W-1:0]        w_slot;
    logic                    w_evict;
    t_count                  w_new_count;
    t_stamp                  w_new_stamp;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!o_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_scan     = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                w_scan = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_UPDATE: begin
                w_commit = !o_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_ctl     = '{start: w_accept, dv: r_dv};
    assign w_page_ext = {{PAGE_BITS{1'b0}}, i_page};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= IDX_W'(LAST_RST);
        end else if (i_cfg_we) begin
            priority if (i_cfg_wdata == '0) begin
                r_last <= '0;
            end else if (int'(i_cfg_wdata) > MAX_FRAMES) begin
                r_last <= IDX_W'(MAX_FRAMES - 1);
            end else begin
                r_last <= IDX_W'(i_cfg_wdata - CFG_W'(1));
            end
        end
    end

    // advance the scan address; hold the key
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= '0;
            r_key <= w_page_ext[PAGE_BITS-1:0];
        end else if (w_scan) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_didx <= r_idx;
    end

    lfupr_frame_mem #(
        .DEPTH     (MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_frame_mem (
        .i_clk      (i_clk),
        .i_rd_addr  (r_idx),
        .o_rd_page  (w_rd_page),
        .o_rd_count (w_rd_count),
        .o_rd_stamp (w_rd_stamp),
        .i_wr_en    (w_commit),
        .i_wr_addr  (w_slot),
        .i_wr_page  (r_key),
        .i_wr_count (w_new_count),
        .i_wr_stamp (w_new_stamp)
    );

    lfupr_scan #(
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_idx         (r_didx),
        .i_valid       (r_valid[r_didx]),
        .i_key         (r_key),
        .i_rd_page     (w_rd_page),
        .i_rd_count    (w_rd_count),
        .i_rd_stamp    (w_rd_stamp),
        .o_hit_found   (w_hit_found),
        .o_hit_idx     (w_hit_idx),
        .o_hit_count   (w_hit_count),
        .o_empty_found (w_empty_found),
        .o_empty_idx   (w_empty_idx),
        .o_victim_idx  (w_victim_idx),
        .o_victim_page (w_victim_page)
    );

    always_comb begin
        priority if (w_hit_found) begin
            w_slot = w_hit_idx;
        end else if (w_empty_found) begin
            w_slot = w_empty_idx;
        end else begin
            w_slot = w_victim_idx;
        end
    end

    assign w_evict     = !w_hit_found && !w_empty_found;
    assign w_new_stamp = r_stamp + STAMP_W'(1);
    assign w_new_count = !w_hit_found ? COUNT_W'(1) :
                         (w_hit_count == COUNT_MAX) ? w_hit_count :
                         w_hit_count + COUNT_W'(1);
    assign w_evict_ext = {{PAGE_W{1'b0}}, w_victim_page};
    assign w_slot_ext  = {{SLOT_W{1'b0}}, w_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_stamp  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else if (w_commit) begin
            r_valid[w_slot] <= 1'b1;
            r_stamp         <= w_new_stamp;
            if (w_hit_found) begin
                r_hits <= r_hits + TOTAL_W'(1);
            end else begin
                r_misses <= r_misses + TOTAL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_commit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            o_hit           <= w_hit_found;
            o_slot          <= w_slot_ext[SLOT_W-1:0];
            o_evicted_valid <= w_evict;
            o_evicted_page  <= w_evict ? w_evict_ext[PAGE_W-1:0] : '0;
            o_hit_total     <= w_hit_found ? r_hits + TOTAL_W'(1) : r_hits;
            o_miss_total    <= w_hit_found ? r_misses : r_misses + TOTAL_W'(1);
        end
    end

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_dv)
        else $error("scan pipeline not drained in idle");

    a_slot_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_valid[$past(w_slot)])
        else $error("written frame not marked valid");

    a_slot_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !w_hit_found) |-> (w_slot <= r_last))
        else $error("filled frame outside the active range");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> ((r_hits + r_misses) == ($past(r_hits + r_misses) + TOTAL_W'(1))))
        else $error("totals did not advance by one word");

endmodule
`default_nettype wire
